// File: rtl/core/fcp_pkg.sv
// Shared types, codes and constants of the floppy controller command phases block.
`timescale 1ns / 1ps

package fcp_pkg;

    localparam int CMD_BYTES    = 16;
    localparam int RESULT_BYTES = 8;

    localparam int CMD_IDX_W = $clog2(CMD_BYTES);
    localparam int CMD_CNT_W = $clog2(CMD_BYTES + 1);
    localparam int RES_IDX_W = $clog2(RESULT_BYTES);
    localparam int RES_CNT_W = $clog2(RESULT_BYTES + 1);

    localparam int SECTOR_W = 24;

    // Event kinds
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_DMA   = 2'd2;
    localparam logic [1:0] MODE_POLL  = 2'd3;

    // Register offsets
    localparam logic [2:0] PORT_DOR    = 3'd2;
    localparam logic [2:0] PORT_STATUS = 3'd4;
    localparam logic [2:0] PORT_FIFO   = 3'd5;

    // Controller phases
    localparam logic [1:0] PH_COMMAND = 2'd0;
    localparam logic [1:0] PH_EXEC    = 2'd1;
    localparam logic [1:0] PH_RESULT  = 2'd2;

    // Opcodes (low five bits of the first command byte)
    localparam logic [4:0] OP_MASK        = 5'h1F;
    localparam logic [4:0] OP_SPECIFY     = 5'h03;
    localparam logic [4:0] OP_SENSE_DRIVE = 5'h04;
    localparam logic [4:0] OP_WRITE_DATA  = 5'h05;
    localparam logic [4:0] OP_READ_DATA   = 5'h06;
    localparam logic [4:0] OP_RECALIBRATE = 5'h07;
    localparam logic [4:0] OP_SENSE_INT   = 5'h08;
    localparam logic [4:0] OP_READ_ID     = 5'h0A;
    localparam logic [4:0] OP_SEEK        = 5'h0F;

    localparam logic [7:0] ST0_SENSE_INT  = 8'h20;
    localparam logic [7:0] STATUS_RQM     = 8'h80;
    localparam logic [7:0] STATUS_RESULT  = 8'h50;
    localparam logic [7:0] STATUS_BUSY    = 8'h10;
    localparam int         DOR_RESET_BIT  = 2;

    localparam logic [2:0] RES_LEN_SENSE = 3'd2;
    localparam logic [2:0] RES_LEN_DATA  = 3'd7;

    // Configuration register indexes
    localparam int         CFG_IDX_W   = 1;
    localparam logic [0:0] CFG_HEADS   = 1'b0;
    localparam logic [0:0] CFG_SPT     = 1'b1;
    localparam logic [7:0] HEADS_RESET = 8'd2;
    localparam logic [7:0] SPT_RESET   = 8'd18;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] port_offset;
        logic [7:0] write_data;
    } fcp_in_t;

    typedef struct packed {
        logic [7:0]          read_data;
        logic                dma_pending;
        logic                dma_to_memory;
        logic [SECTOR_W-1:0] sector_address;
        logic                sector_load;
        logic                sector_flush;
        logic                irq_taken;
        logic                irq_pending;
    } fcp_out_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic mul_a;
        logic mul_b;
        logic emit;
    } fcp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_mul;
    } fcp_status_t;

    // Whole command length in bytes, opcode included; zero for an unknown opcode.
    function automatic logic [3:0] cmd_total(input logic [7:0] op_byte);
        logic [4:0] op;
        op = op_byte[4:0] & OP_MASK;
        case (op)
            OP_READ_DATA:   cmd_total = 4'd9;
            OP_WRITE_DATA:  cmd_total = 4'd9;
            OP_READ_ID:     cmd_total = 4'd2;
            OP_SPECIFY:     cmd_total = 4'd3;
            OP_RECALIBRATE: cmd_total = 4'd2;
            OP_SEEK:        cmd_total = 4'd3;
            OP_SENSE_DRIVE: cmd_total = 4'd2;
            OP_SENSE_INT:   cmd_total = 4'd1;
            default:        cmd_total = 4'd0;
        endcase
    endfunction

endpackage

// File: rtl/core/fcp_ctrl.sv
// Sequencing state machine and output handshake of the floppy controller block.
`timescale 1ns / 1ps

module fcp_ctrl
    import fcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  fcp_status_t status,
    output fcp_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_MUL_A = 3'd2;
    localparam logic [2:0] S_MUL_B = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.need_mul ? S_MUL_A : S_EMIT;
            end
            S_MUL_A:
            begin
                cmd.mul_a  = 1'b1;
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                cmd.mul_b  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/fcp_datapath.sv
// Register file, command and result stores, event decode and sector address unit.
`timescale 1ns / 1ps

module fcp_datapath
    import fcp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fcp_in_t              in_data,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  fcp_cmd_t             cmd,
    output fcp_status_t          status,
    output fcp_out_t             out_data
);

    // configuration
    logic [7:0] heads_reg;
    logic [7:0] spt_reg;

    // controller state
    logic [7:0]           dor_reg,        dor_next;
    logic [1:0]           phase_reg,      phase_next;
    logic [CMD_CNT_W-1:0] cmd_count_reg,  cmd_count_next;
    logic [3:0]           cmd_needed_reg, cmd_needed_next;
    logic [2:0]           res_len_reg,    res_len_next;
    logic [RES_IDX_W-1:0] res_idx_reg,    res_idx_next;
    logic                 pending_reg,    pending_next;
    logic                 to_mem_reg,     to_mem_next;
    logic                 irq_reg,        irq_next;
    logic [SECTOR_W-1:0]  sector_reg;

    // stores
    logic [7:0] cmd_mem [CMD_BYTES];
    logic [7:0] res_mem [RESULT_BYTES];

    // per-transaction payload
    fcp_in_t    item_reg;
    logic [7:0] rd_reg,    rd_next;
    logic       load_reg,  load_next;
    logic       flush_reg, flush_next;
    logic       taken_reg, taken_next;
    logic [15:0] prod_reg;
    fcp_out_t   out_reg;

    logic       cmd_we;
    logic       res_sense_we;
    logic       res_dma_we;
    logic       need_mul;
    logic [7:0] status_byte;
    logic [7:0] sector_r;

    always_comb
    begin
        status_byte = STATUS_RQM;
        if (phase_reg == PH_RESULT)
            status_byte = status_byte | STATUS_RESULT;
        else if (pending_reg)
            status_byte = status_byte | STATUS_BUSY;
    end

    // event decode, applied in the execute step
    always_comb
    begin
        logic                 accept;
        logic [3:0]           needed_eff;
        logic [3:0]           total;
        logic [CMD_CNT_W-1:0] count_after;
        logic [4:0]           op;
        logic [RES_CNT_W-1:0] idx_plus;

        dor_next        = dor_reg;
        phase_next      = phase_reg;
        cmd_count_next  = cmd_count_reg;
        cmd_needed_next = cmd_needed_reg;
        res_len_next    = res_len_reg;
        res_idx_next    = res_idx_reg;
        pending_next    = pending_reg;
        to_mem_next     = to_mem_reg;
        irq_next        = irq_reg;
        rd_next         = 8'h00;
        load_next       = 1'b0;
        flush_next      = 1'b0;
        taken_next      = 1'b0;
        cmd_we          = 1'b0;
        res_sense_we    = 1'b0;
        res_dma_we      = 1'b0;
        need_mul        = 1'b0;
        accept          = 1'b1;
        needed_eff      = cmd_needed_reg;
        total           = cmd_total(item_reg.write_data);
        count_after     = cmd_count_reg;
        op              = (cmd_count_reg == '0) ? (item_reg.write_data[4:0] & OP_MASK)
                                                : (cmd_mem[0][4:0] & OP_MASK);
        idx_plus        = RES_CNT_W'(res_idx_reg) + RES_CNT_W'(1);

        case (item_reg.mode)
            MODE_READ:
            begin
                if (item_reg.port_offset == PORT_DOR)
                    rd_next = dor_reg;
                else if (item_reg.port_offset == PORT_STATUS)
                    rd_next = status_byte;
                else if (item_reg.port_offset == PORT_FIFO)
                begin
                    if (phase_reg == PH_RESULT && res_idx_reg < RES_IDX_W'(res_len_reg)
                        && RES_CNT_W'(res_idx_reg) < RES_CNT_W'(RESULT_BYTES))
                    begin
                        rd_next      = res_mem[res_idx_reg];
                        res_idx_next = res_idx_reg + RES_IDX_W'(1);
                        if (idx_plus >= RES_CNT_W'(res_len_reg))
                            phase_next = PH_COMMAND;
                    end
                end
            end
            MODE_WRITE:
            begin
                if (item_reg.port_offset == PORT_DOR)
                begin
                    dor_next = item_reg.write_data;
                    // reset released: back to command phase
                    if (!dor_reg[DOR_RESET_BIT] && item_reg.write_data[DOR_RESET_BIT])
                    begin
                        phase_next     = PH_COMMAND;
                        cmd_count_next = '0;
                        irq_next       = 1'b1;
                    end
                end
                else if (item_reg.port_offset == PORT_FIFO && phase_reg == PH_COMMAND)
                begin
                    if (cmd_count_reg == '0)
                    begin
                        if (total == 4'd0)
                            accept = 1'b0;
                        else
                        begin
                            cmd_needed_next = total;
                            needed_eff      = total;
                        end
                    end
                    if (accept)
                    begin
                        if (cmd_count_reg < CMD_CNT_W'(CMD_BYTES))
                        begin
                            cmd_we      = 1'b1;
                            count_after = cmd_count_reg + CMD_CNT_W'(1);
                        end
                        cmd_count_next = count_after;
                        if (count_after == CMD_CNT_W'(needed_eff))
                        begin
                            cmd_count_next = '0;
                            if (op == OP_READ_DATA || op == OP_WRITE_DATA)
                            begin
                                to_mem_next  = (op == OP_READ_DATA);
                                load_next    = (op == OP_READ_DATA);
                                pending_next = 1'b1;
                                phase_next   = PH_EXEC;
                                need_mul     = 1'b1;
                            end
                            else if (op == OP_SENSE_INT)
                            begin
                                res_sense_we = 1'b1;
                                res_len_next = RES_LEN_SENSE;
                                res_idx_next = '0;
                                phase_next   = PH_RESULT;
                            end
                            else
                            begin
                                if (op == OP_RECALIBRATE || op == OP_SEEK)
                                    irq_next = 1'b1;
                                phase_next = PH_COMMAND;
                            end
                        end
                    end
                end
            end
            MODE_DMA:
            begin
                if (pending_reg)
                begin
                    flush_next   = !to_mem_reg;
                    pending_next = 1'b0;
                    res_dma_we   = 1'b1;
                    res_len_next = RES_LEN_DATA;
                    res_idx_next = '0;
                    phase_next   = PH_RESULT;
                    irq_next     = 1'b1;
                end
            end
            MODE_POLL:
            begin
                if (irq_reg)
                begin
                    irq_next   = 1'b0;
                    taken_next = 1'b1;
                end
            end
            default:
            begin
                rd_next = 8'h00;
            end
        endcase
    end

    assign status.need_mul = need_mul;
    assign sector_r = cmd_mem[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heads_reg      <= HEADS_RESET;
            spt_reg        <= SPT_RESET;
            dor_reg        <= '0;
            phase_reg      <= PH_COMMAND;
            cmd_count_reg  <= '0;
            cmd_needed_reg <= '0;
            res_len_reg    <= '0;
            res_idx_reg    <= '0;
            pending_reg    <= 1'b0;
            to_mem_reg     <= 1'b0;
            irq_reg        <= 1'b0;
            sector_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_HEADS: heads_reg <= cfg_data;
                    CFG_SPT:   spt_reg   <= cfg_data;
                    default:   heads_reg <= heads_reg;
                endcase
            end
            if (cmd.exec)
            begin
                dor_reg        <= dor_next;
                phase_reg      <= phase_next;
                cmd_count_reg  <= cmd_count_next;
                cmd_needed_reg <= cmd_needed_next;
                res_len_reg    <= res_len_next;
                res_idx_reg    <= res_idx_next;
                pending_reg    <= pending_next;
                to_mem_reg     <= to_mem_next;
                irq_reg        <= irq_next;
            end
            // second multiply step: scale by sectors per track, add sector offset
            if (cmd.mul_b)
                sector_reg <= SECTOR_W'(prod_reg) * SECTOR_W'(spt_reg)
                            + SECTOR_W'((sector_r != 8'd0) ? (sector_r - 8'd1) : 8'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_data;
        if (cmd.exec)
        begin
            rd_reg    <= rd_next;
            load_reg  <= load_next;
            flush_reg <= flush_next;
            taken_reg <= taken_next;
            if (cmd_we)
                cmd_mem[cmd_count_reg[CMD_IDX_W-1:0]] <= item_reg.write_data;
            if (res_sense_we)
            begin
                res_mem[0] <= ST0_SENSE_INT;
                res_mem[1] <= 8'h00;
            end
            if (res_dma_we)
            begin
                res_mem[0] <= 8'h00;
                res_mem[1] <= 8'h00;
                res_mem[2] <= 8'h00;
                res_mem[3] <= cmd_mem[2];
                res_mem[4] <= cmd_mem[3];
                res_mem[5] <= cmd_mem[4] + 8'd1;
                res_mem[6] <= cmd_mem[5];
            end
        end
        // first multiply step: cylinder times heads plus head
        if (cmd.mul_a)
            prod_reg <= (16'(cmd_mem[2]) * 16'(heads_reg)) + 16'(cmd_mem[3]);
        if (cmd.emit)
        begin
            out_reg.read_data      <= rd_reg;
            out_reg.dma_pending    <= pending_reg;
            out_reg.dma_to_memory  <= to_mem_reg;
            out_reg.sector_address <= sector_reg;
            out_reg.sector_load    <= load_reg;
            out_reg.sector_flush   <= flush_reg;
            out_reg.irq_taken      <= taken_reg;
            out_reg.irq_pending    <= irq_reg;
        end
    end

    assign out_data = out_reg;

endmodule

// File: rtl/core/floppy_controller_command_phases.sv
// Top level of the floppy controller command phases block.
`timescale 1ns / 1ps
//
// One input transaction is one host event: a bus read, a bus write, a DMA
// completion or an interrupt poll. Each event gives exactly one result
// transaction carrying the read byte, the transfer state, the sector address,
// the load/flush/taken pulses and the interrupt level after the event.
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low. heads and sectors_per_track must be written through the
// plain cfg_write/cfg_index/cfg_data port while the block is idle; the block
// does not enforce this. An event is captured on acceptance, decoded in the
// execute step and put in the output register by the emit step; the FIFO
// write that completes a Read Data or Write Data command also passes, between
// execute and emit, the two multiply steps that form its sector address.
// The controller sequences one event at a time and takes no new event before
// the last one is emitted. A waiting result sits in the output register; the
// next event is accepted meanwhile and is held before its own emit step while
// the receiver stalls. Reset clears DOR, phase, counts, flags and sector
// address and restores heads 2 and 18 sectors per track; no result is valid.
//
module floppy_controller_command_phases
    import fcp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  fcp_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output fcp_out_t             out_data,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    fcp_cmd_t    cmd;
    fcp_status_t status;

    fcp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    fcp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

`ifndef NO_ASSERTIONS
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> cmd.exec)
        else $error("accepted transaction not executed next cycle");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid && out_stall))
        else $error("result emitted over a stalled result");

    a_mul_seq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_a |=> cmd.mul_b)
        else $error("sector multiply steps out of order");

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.emit))
        else $error("output valid raised without an emit step");
`endif

endmodule
